FILE: rtl/md5sh_pkg.sv
`default_nettype none

package md5sh_pkg;

  // Depth of the request queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // MD5 initial chaining value.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // First padding byte after the message.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Request kinds, with the codes seen on the input port.
  typedef enum logic [1:0] {
    REQ_ABSORB = 2'd0,
    REQ_DIGEST = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_kind_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  data;
  } req_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ADD
  } core_state_t;

  // How the message words of the current block are formed.
  typedef enum logic [1:0] {
    MODE_PLAIN,   // full block straight from the buffer
    MODE_FIRST,   // padded block without length, another block follows
    MODE_SINGLE,  // padded block that carries the length
    MODE_SECOND   // all-zero block that carries the length
  } blk_mode_t;

  // Additive round constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by round group and round number modulo four.
  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] j;
    logic [3:0] g;
    j = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    g = j;
      2'd1:    g = 4'((j << 2) + j + 4'd1);
      2'd2:    g = 4'((j << 1) + j + 4'd5);
      default: g = 4'((j << 3) - j);
    endcase
    return g;
  endfunction

  // Rotate amount of a round.
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    return ROT_AMT[{rnd[5:4], rnd[1:0]}];
  endfunction

  // Round function of the four groups.
  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  // Left rotate of a 32-bit word.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/md5sh_front.sv
`default_nettype none

module md5sh_front #(
  parameter int DEPTH = md5sh_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  wire  [1:0]          in_req_type,
  input  wire  [7:0]          in_data_byte,
  output logic                req_valid,
  output md5sh_pkg::req_t     req,
  input  wire                 req_take
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  md5sh_pkg::req_t q_r [DEPTH];
  logic [PW-1:0]   head_r;
  logic [PW-1:0]   tail_r;
  logic [CW-1:0]   count_r;
  logic            keep;
  md5sh_pkg::req_t cls;
  logic            wr_en;
  logic            rd_en;

  // Classify the incoming beat; the unused request code is dropped here.
  always_comb begin
    keep     = 1'b1;
    cls.data = in_data_byte;
    cls.kind = md5sh_pkg::REQ_ABSORB;
    unique case (in_req_type)
      md5sh_pkg::REQ_ABSORB: cls.kind = md5sh_pkg::REQ_ABSORB;
      md5sh_pkg::REQ_DIGEST: cls.kind = md5sh_pkg::REQ_DIGEST;
      md5sh_pkg::REQ_CLEAR:  cls.kind = md5sh_pkg::REQ_CLEAR;
      default:               keep = 1'b0;
    endcase
  end

  assign full      = (count_r == CW'(DEPTH));
  assign req_valid = (count_r != '0);
  assign req       = q_r[head_r];
  assign wr_en     = push && !full && keep;
  assign rd_en     = req_take && req_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[tail_r] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        tail_r <= (tail_r == PW'(DEPTH - 1)) ? '0 : PW'(tail_r + 1'b1);
      end
      if (rd_en) begin
        head_r <= (head_r == PW'(DEPTH - 1)) ? '0 : PW'(head_r + 1'b1);
      end
      if (wr_en && !rd_en) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (!wr_en && rd_en) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/md5sh_core.sv
`default_nettype none

module md5sh_core (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              req_valid,
  input  md5sh_pkg::req_t  req,
  output logic             req_take,
  output logic             empty,
  input  wire              pop,
  output logic [31:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_word
);

  // The round counter leads the rounds by RUN_LEAD to cover the buffer read pipeline.
  localparam logic [6:0] RUN_LAST = 7'd65;
  localparam logic [6:0] RUN_LEAD = 7'd2;

  md5sh_pkg::core_state_t st_r, st_nxt;
  md5sh_pkg::blk_mode_t   mode_r, mode_nxt;
  logic [6:0]             cnt_r, cnt_nxt;

  logic [31:0] cv_r   [4];
  logic [31:0] base_r [4];
  logic [31:0] wv_r   [4];
  logic [31:0] sum    [4];
  logic [60:0] byte_cnt_r;
  logic [5:0]  pos;

  logic [7:0]  buf_mem [4][16];
  logic [31:0] rd_word_r;
  logic [3:0]  s2_g_r;
  logic [5:0]  s2_idx_r;
  logic [31:0] km_r;
  logic [31:0] pad_word;
  logic [3:0]  rd_addr;

  logic [31:0] out_words_r [4];
  logic [1:0]  out_idx_r;
  logic        out_pend_r;
  logic        out_pop;

  logic        absorb_we;
  logic        start_cv;
  logic        clear_st;
  logic        fin_plain;
  logic        fin_first;
  logic        fin_out;
  logic        round_en;
  logic [5:0]  rnd;
  logic [31:0] new_b;

  assign pos = byte_cnt_r[5:0];
  assign rnd = 6'(cnt_r - RUN_LEAD);

  // Sequencer: takes requests in idle, runs 64 rounds, then folds in the sum.
  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    req_take  = 1'b0;
    absorb_we = 1'b0;
    start_cv  = 1'b0;
    clear_st  = 1'b0;
    fin_plain = 1'b0;
    fin_first = 1'b0;
    fin_out   = 1'b0;
    round_en  = 1'b0;
    unique case (st_r)
      md5sh_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (req.kind)
            md5sh_pkg::REQ_ABSORB: begin
              req_take  = 1'b1;
              absorb_we = 1'b1;
              if (pos == 6'd63) begin
                start_cv = 1'b1;
                mode_nxt = md5sh_pkg::MODE_PLAIN;
                cnt_nxt  = '0;
                st_nxt   = md5sh_pkg::ST_RUN;
              end
            end
            md5sh_pkg::REQ_DIGEST: begin
              if (!out_pend_r) begin
                req_take = 1'b1;
                start_cv = 1'b1;
                mode_nxt = (pos[5:3] == 3'b111) ? md5sh_pkg::MODE_FIRST
                                                : md5sh_pkg::MODE_SINGLE;
                cnt_nxt  = '0;
                st_nxt   = md5sh_pkg::ST_RUN;
              end
            end
            md5sh_pkg::REQ_CLEAR: begin
              req_take = 1'b1;
              clear_st = 1'b1;
            end
            default: ;
          endcase
        end
      end
      md5sh_pkg::ST_RUN: begin
        round_en = (cnt_r >= RUN_LEAD);
        cnt_nxt  = 7'(cnt_r + 1'b1);
        if (cnt_r == RUN_LAST) begin
          st_nxt = md5sh_pkg::ST_ADD;
        end
      end
      md5sh_pkg::ST_ADD: begin
        unique case (mode_r)
          md5sh_pkg::MODE_PLAIN: begin
            fin_plain = 1'b1;
            st_nxt    = md5sh_pkg::ST_IDLE;
          end
          md5sh_pkg::MODE_FIRST: begin
            fin_first = 1'b1;
            mode_nxt  = md5sh_pkg::MODE_SECOND;
            cnt_nxt   = '0;
            st_nxt    = md5sh_pkg::ST_RUN;
          end
          default: begin
            fin_out = 1'b1;
            st_nxt  = md5sh_pkg::ST_IDLE;
          end
        endcase
      end
      default: st_nxt = md5sh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= md5sh_pkg::ST_IDLE;
      mode_r <= md5sh_pkg::MODE_PLAIN;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Block buffer: one byte written per absorb, one word read per cycle.
  assign rd_addr = md5sh_pkg::msg_index(cnt_r[5:0]);

  always_ff @(posedge clk) begin
    if (absorb_we) begin
      buf_mem[pos[1:0]][pos[5:2]] <= req.data;
    end
    rd_word_r <= {buf_mem[3][rd_addr], buf_mem[2][rd_addr],
                  buf_mem[1][rd_addr], buf_mem[0][rd_addr]};
    s2_g_r    <= rd_addr;
    s2_idx_r  <= cnt_r[5:0];
  end

  // Padding: bytes past the fill level become the marker and zeros, and the
  // last two words of the final block carry the bit length.
  always_comb begin
    pad_word = rd_word_r;
    if (mode_r == md5sh_pkg::MODE_FIRST || mode_r == md5sh_pkg::MODE_SINGLE) begin
      for (int l = 0; l < 4; l++) begin
        if ({s2_g_r, 2'(l)} == pos) begin
          pad_word[8*l +: 8] = md5sh_pkg::PAD_BYTE;
        end else if ({s2_g_r, 2'(l)} > pos) begin
          pad_word[8*l +: 8] = '0;
        end
      end
    end else if (mode_r == md5sh_pkg::MODE_SECOND) begin
      pad_word = '0;
    end
    if (mode_r == md5sh_pkg::MODE_SINGLE || mode_r == md5sh_pkg::MODE_SECOND) begin
      if (s2_g_r == 4'd14) begin
        pad_word = {byte_cnt_r[28:0], 3'b000};
      end else if (s2_g_r == 4'd15) begin
        pad_word = byte_cnt_r[60:29];
      end
    end
  end

  always_ff @(posedge clk) begin
    km_r <= md5sh_pkg::ROUND_K[s2_idx_r] + pad_word;
  end

  // One MD5 round per cycle.
  assign new_b = wv_r[1] + md5sh_pkg::rotl32(
                   wv_r[0] + md5sh_pkg::round_f(rnd[5:4], wv_r[1], wv_r[2], wv_r[3]) + km_r,
                   md5sh_pkg::rot_amount(rnd));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = base_r[k] + wv_r[k];
    end
  end

  // Working variables and the base of the current compression.
  always_ff @(posedge clk) begin
    if (start_cv) begin
      base_r <= cv_r;
      wv_r   <= cv_r;
    end else if (fin_first) begin
      base_r <= sum;
      wv_r   <= sum;
    end else if (round_en) begin
      wv_r[0] <= wv_r[3];
      wv_r[1] <= new_b;
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
    end
    if (fin_out) begin
      out_words_r <= sum;
    end
  end

  // Running chaining value and byte count.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_st) begin
      cv_r[0]    <= md5sh_pkg::IV_A;
      cv_r[1]    <= md5sh_pkg::IV_B;
      cv_r[2]    <= md5sh_pkg::IV_C;
      cv_r[3]    <= md5sh_pkg::IV_D;
      byte_cnt_r <= '0;
    end else begin
      if (absorb_we) begin
        byte_cnt_r <= 61'(byte_cnt_r + 1'b1);
      end
      if (fin_plain) begin
        cv_r <= sum;
      end
    end
  end

  // Result buffer drains the four digest words one beat at a time.
  assign empty           = !out_pend_r;
  assign out_pop         = pop && out_pend_r;
  assign out_digest_word = out_words_r[out_idx_r];
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_pend_r <= 1'b0;
      out_idx_r  <= '0;
    end else if (fin_out) begin
      out_pend_r <= 1'b1;
      out_idx_r  <= '0;
    end else if (out_pop) begin
      if (out_idx_r == 2'd3) begin
        out_pend_r <= 1'b0;
      end
      out_idx_r <= 2'(out_idx_r + 1'b1);
    end
  end

  // A digest only starts once the previous one has been fully read out.
  a_digest_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && req.kind == md5sh_pkg::REQ_DIGEST) |-> !out_pend_r)
    else $error("digest started while results still pending");

  // The last round counter value always leads to the final add.
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == md5sh_pkg::ST_RUN && cnt_r == RUN_LAST) |=> st_r == md5sh_pkg::ST_ADD)
    else $error("compression did not end after the last round");

  // The byte count, which sets the padding, holds during a compression.
  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == md5sh_pkg::ST_RUN) |=> $stable(byte_cnt_r))
    else $error("byte count moved during compression");

  // The word index only moves on a pop.
  a_index_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pend_r && !pop) |=> $stable(out_idx_r))
    else $error("digest word index moved without a pop");

endmodule

`default_nettype wire

FILE: rtl/md5_stream_hash.sv
// MD5 digest over a byte stream.
// Requests enter through a queue port: a beat is taken when push is high and
// full is low. in_req_type selects absorb (append in_data_byte), digest (read
// the digest of the message so far) or clear (restart); code 3 is dropped.
// Digest words leave through a queue port: while empty is low the oldest word
// is on out_digest_word with out_word_index and out_last_word, and pop takes it.
// A digest request gives four beats, words A to D, and leaves the running
// hash untouched.
// A small request queue sits in front of the hashing engine, so requests keep
// being taken while the engine works or while digest words wait to be popped.
// The engine takes one absorbed byte per cycle while it is idle; the 64th byte of a
// block keeps it busy through the buffer read lead, 64 rounds at one round per
// cycle in the single round unit, and the final add.
// With an idle queue and engine, the first digest word shows after one compression
// of the padded block, or after two when the padding spills into a second block.
// A new digest waits in the engine until all four words of the previous one
// have been popped; meanwhile the request queue fills and full rises.
// Synchronous reset clears the queue and result buffer and loads the initial
// vector with a zero bit count; the block buffer needs no clearing.
`default_nettype none

module md5_stream_hash #(
  parameter int QUEUE_DEPTH = md5sh_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  output logic        full,
  input  wire  [1:0]  in_req_type,
  input  wire  [7:0]  in_data_byte,
  output logic        empty,
  input  wire         pop,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  logic            req_valid;
  md5sh_pkg::req_t req;
  logic            req_take;

  md5sh_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .req_valid    (req_valid),
    .req          (req),
    .req_take     (req_take)
  );

  md5sh_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req             (req),
    .req_take        (req_take),
    .empty           (empty),
    .pop             (pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire
